// ===== design/ifmt_pkg.sv =====
// Shared types, constants and helpers of the IP address text formatter.
`default_nettype none
package ifmt_pkg;

    localparam int NUM_LANES = 16;
    localparam int SEG_CHARS = 5;
    localparam int CHAR_W    = 7;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_LOWA  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2e;
    localparam logic [CHAR_W-1:0] CH_COLON = 7'h3a;
    localparam logic [CHAR_W-1:0] CH_QUEST = 7'h3f;
    localparam logic [CHAR_W-1:0] CH_LT    = 7'h3c;
    localparam logic [CHAR_W-1:0] CH_GT    = 7'h3e;
    localparam logic [CHAR_W-1:0] CH_N     = 7'h6e;
    localparam logic [CHAR_W-1:0] CH_I     = 7'h69;
    localparam logic [CHAR_W-1:0] CH_L     = 7'h6c;

    typedef enum logic [2:0] {
        MODE_NIL,
        MODE_DOT,
        MODE_MAPPED,
        MODE_IPV6,
        MODE_RAW
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [2:0]  run_start;
        logic [3:0]  run_len;    // zero when no run of two or more zero groups
        logic [4:0]  raw_cnt;
    } t_scan;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  byte_val;
        logic [15:0] group_val;
        logic        first;
        logic        lane_on;
        logic        in_run;
        logic        run_head;
        logic        after_run;
    } t_lane_in;

    typedef struct packed {
        logic [SEG_CHARS-1:0][CHAR_W-1:0] chars;
        logic [2:0]                       len;
    } t_seg;

    typedef t_seg [NUM_LANES-1:0] t_seg_vec;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {3'b000, nib};
        end else begin
            c = CH_LOWA + {3'b000, nib} - 7'd10;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/ip_address_text_formatter_unit.sv =====
// Top level of the IP address text formatter: input stages, 16 lanes, merge stage.
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+-------------------------
//  item    | in        | i_addr_len, i_addr_high, i_addr_low     | i_start high, o_busy low
//  result  | out       | o_text_char, o_last_char                | o_strobe, one cycle each
//
// One character leaves per cycle while an item streams, and the text of an item has 2 to
// 39 characters; the merge stage streams the lane pieces. The first character of an item
// reaches the result ports after input stage 1, input stage 2 and the pending and active
// registers of the merge stage; a new item is taken while the previous one is still
// streaming. i_rst_n is synchronous and active low and empties every stage. The receiver
// cannot stall; o_busy rises only when the stages fill.
`default_nettype none
module ip_address_text_formatter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [4:0]  i_addr_len,
    input  wire logic [63:0] i_addr_high,
    input  wire logic [63:0] i_addr_low,
    output logic             o_strobe,
    output logic [6:0]       o_text_char,
    output logic             o_last_char
);

    logic                r_s1_v, n_s1_v;
    logic [4:0]          r_s1_len;
    logic [63:0]         r_s1_high;
    logic [63:0]         r_s1_low;
    logic                r_s2_v, n_s2_v;
    ifmt_pkg::t_scan     r_s2_scan;
    logic [127:0]        r_s2_addr;

    ifmt_pkg::t_scan     scan;
    ifmt_pkg::t_lane_in  lane_in [ifmt_pkg::NUM_LANES];
    ifmt_pkg::t_seg_vec  segs;
    logic                seg_ready;
    logic                accept;
    logic                s1_adv;
    logic                s2_adv;
    logic [4:0]          run_end;

    assign s2_adv = r_s2_v && seg_ready;
    assign s1_adv = r_s1_v && (!r_s2_v || s2_adv);
    assign o_busy = r_s1_v && !s1_adv;
    assign accept = i_start && !o_busy;

    always_comb begin
        n_s1_v = accept ? 1'b1 : (s1_adv ? 1'b0 : r_s1_v);
        n_s2_v = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : r_s2_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= n_s1_v;
            r_s2_v <= n_s2_v;
        end
    end

    // hold each stage until the next one takes it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_len  <= i_addr_len;
            r_s1_high <= i_addr_high;
            r_s1_low  <= i_addr_low;
        end
        if (s1_adv) begin
            r_s2_scan <= scan;
            r_s2_addr <= {r_s1_high, r_s1_low};
        end
    end

    ifmt_scan u_scan (
        .i_addr_len  (r_s1_len),
        .i_addr_high (r_s1_high),
        .i_addr_low  (r_s1_low),
        .o_scan      (scan)
    );

    assign run_end = {2'b00, r_s2_scan.run_start} + {1'b0, r_s2_scan.run_len};

    for (genvar k = 0; k < ifmt_pkg::NUM_LANES; k++) begin : g_lane
        localparam int            MAP_IDX = (k + 12) % ifmt_pkg::NUM_LANES;
        localparam int            GRP_IDX = k % 8;
        localparam logic [4:0]    K5      = 5'(k);

        always_comb begin
            lane_in[k].mode      = r_s2_scan.mode;
            lane_in[k].byte_val  = (r_s2_scan.mode == ifmt_pkg::MODE_MAPPED)
                                 ? r_s2_addr[127-8*MAP_IDX -: 8]
                                 : r_s2_addr[127-8*k -: 8];
            lane_in[k].group_val = r_s2_addr[127-16*GRP_IDX -: 16];
            lane_in[k].first     = (k == 0);
            lane_in[k].in_run    = (r_s2_scan.run_len != 4'd0)
                                 && (K5 >= {2'b00, r_s2_scan.run_start})
                                 && (K5 < run_end);
            lane_in[k].run_head  = (r_s2_scan.run_len != 4'd0)
                                 && (K5 == {2'b00, r_s2_scan.run_start});
            lane_in[k].after_run = (r_s2_scan.run_len != 4'd0) && (K5 == run_end);
            case (r_s2_scan.mode)
                ifmt_pkg::MODE_NIL:                        lane_in[k].lane_on = (k == 0);
                ifmt_pkg::MODE_DOT, ifmt_pkg::MODE_MAPPED: lane_in[k].lane_on = (k < 4);
                ifmt_pkg::MODE_IPV6:                       lane_in[k].lane_on = (k < 8);
                ifmt_pkg::MODE_RAW:  lane_in[k].lane_on = (K5 < r_s2_scan.raw_cnt);
                default:                                   lane_in[k].lane_on = 1'b0;
            endcase
        end

        ifmt_lane u_lane (
            .i_in  (lane_in[k]),
            .o_seg (segs[k])
        );
    end

    ifmt_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (r_s2_v),
        .i_segs      (segs),
        .o_seg_ready (seg_ready),
        .o_strobe    (o_strobe),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule
`default_nettype wire

// ===== design/ifmt_scan.sv =====
// Classifies an address and finds the first longest run of zero groups.
`default_nettype none
module ifmt_scan (
    input  wire logic [4:0]      i_addr_len,
    input  wire logic [63:0]     i_addr_high,
    input  wire logic [63:0]     i_addr_low,
    output ifmt_pkg::t_scan      o_scan
);

    logic [127:0] addr;
    logic [7:0]   zg;
    logic [3:0]   run;
    logic [3:0]   best_len;
    logic [2:0]   best_start;
    logic         mapped;

    assign addr = {i_addr_high, i_addr_low};

    always_comb begin
        for (int g = 0; g < 8; g++) begin
            zg[g] = (addr[127-16*g -: 16] == 16'h0000);
        end
        run        = '0;
        best_len   = '0;
        best_start = '0;
        for (int g = 0; g < 8; g++) begin
            run = zg[g] ? run + 4'd1 : 4'd0;
            if (run > best_len) begin
                best_len   = run;
                best_start = 3'(g) - run[2:0] + 3'd1;
            end
        end
        mapped = (addr[127:48] == 80'h0) && (addr[47:32] == 16'hffff);

        o_scan.run_start = best_start;
        o_scan.run_len   = (best_len < 4'd2) ? 4'd0 : best_len;
        o_scan.raw_cnt   = (i_addr_len > 5'd16) ? 5'd16 : i_addr_len;
        if (i_addr_len == 5'd0) begin
            o_scan.mode = ifmt_pkg::MODE_NIL;
        end else if (i_addr_len == 5'd4) begin
            o_scan.mode = ifmt_pkg::MODE_DOT;
        end else if (i_addr_len == 5'd16) begin
            o_scan.mode = mapped ? ifmt_pkg::MODE_MAPPED : ifmt_pkg::MODE_IPV6;
        end else begin
            o_scan.mode = ifmt_pkg::MODE_RAW;
        end
    end

endmodule
`default_nettype wire

// ===== design/ifmt_lane.sv =====
// One formatting lane: turns one byte or group into its piece of text.
`default_nettype none
module ifmt_lane (
    input  wire ifmt_pkg::t_lane_in i_in,
    output ifmt_pkg::t_seg          o_seg
);

    logic [ifmt_pkg::SEG_CHARS-1:0][ifmt_pkg::CHAR_W-1:0] c;
    logic [2:0]  pos;
    logic [1:0]  hund;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    logic [3:0]  nib;
    logic        started;

    // decimal digits of the byte: hundreds by compare, tens by reciprocal
    always_comb begin
        if (i_in.byte_val >= 8'd200) begin
            hund = 2'd2;
        end else if (i_in.byte_val >= 8'd100) begin
            hund = 2'd1;
        end else begin
            hund = 2'd0;
        end
        rem  = 7'(i_in.byte_val - 8'({6'b0, hund} * 8'd100));
        prod = 15'(rem) * 15'd205;
        tens = prod[14:11];
        ones = rem - 7'({3'b000, tens} * 7'd10);
    end

    always_comb begin
        c       = '0;
        pos     = '0;
        nib     = '0;
        started = 1'b0;
        case (i_in.mode)
            ifmt_pkg::MODE_NIL: begin
                c[0] = ifmt_pkg::CH_LT;
                c[1] = ifmt_pkg::CH_N;
                c[2] = ifmt_pkg::CH_I;
                c[3] = ifmt_pkg::CH_L;
                c[4] = ifmt_pkg::CH_GT;
                pos  = 3'd5;
            end
            ifmt_pkg::MODE_DOT, ifmt_pkg::MODE_MAPPED: begin
                if (!i_in.first) begin
                    c[pos] = ifmt_pkg::CH_DOT;
                    pos    = pos + 3'd1;
                end
                if (i_in.byte_val >= 8'd100) begin
                    c[pos] = ifmt_pkg::CH_ZERO + {5'b0, hund};
                    pos    = pos + 3'd1;
                end
                if (i_in.byte_val >= 8'd10) begin
                    c[pos] = ifmt_pkg::CH_ZERO + {3'b0, tens};
                    pos    = pos + 3'd1;
                end
                c[pos] = ifmt_pkg::CH_ZERO + ones;
                pos    = pos + 3'd1;
            end
            ifmt_pkg::MODE_IPV6: begin
                if (i_in.in_run) begin
                    if (i_in.run_head) begin
                        c[0] = ifmt_pkg::CH_COLON;
                        c[1] = ifmt_pkg::CH_COLON;
                        pos  = 3'd2;
                    end
                end else begin
                    if (!i_in.first && !i_in.after_run) begin
                        c[pos] = ifmt_pkg::CH_COLON;
                        pos    = pos + 3'd1;
                    end
                    // drop leading zero nibbles, keep at least one
                    for (int j = 3; j >= 0; j--) begin
                        nib = i_in.group_val[4*j +: 4];
                        if (nib != 4'h0 || started || j == 0) begin
                            c[pos]  = ifmt_pkg::hex_char(nib);
                            pos     = pos + 3'd1;
                            started = 1'b1;
                        end
                    end
                end
            end
            ifmt_pkg::MODE_RAW: begin
                if (i_in.first) begin
                    c[pos] = ifmt_pkg::CH_QUEST;
                    pos    = pos + 3'd1;
                end
                c[pos] = ifmt_pkg::hex_char(i_in.byte_val[7:4]);
                pos    = pos + 3'd1;
                c[pos] = ifmt_pkg::hex_char(i_in.byte_val[3:0]);
                pos    = pos + 3'd1;
            end
            default: begin
                pos = '0;
            end
        endcase
        o_seg.chars = c;
        o_seg.len   = i_in.lane_on ? pos : 3'd0;
    end

endmodule
`default_nettype wire

// ===== design/ifmt_emit.sv =====
// Merge stage: holds the lane pieces of an item and streams them one char a cycle.
`default_nettype none
module ifmt_emit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_seg_valid,
    input  wire ifmt_pkg::t_seg_vec    i_segs,
    output logic                       o_seg_ready,
    output logic                       o_strobe,
    output logic [ifmt_pkg::CHAR_W-1:0] o_text_char,
    output logic                       o_last_char
);

    logic               r_pend_v, n_pend_v;
    ifmt_pkg::t_seg_vec r_pend, n_pend;
    logic               r_act, n_act;
    ifmt_pkg::t_seg_vec r_segs, n_segs;
    logic [3:0]         r_si, n_si;
    logic [2:0]         r_ci, n_ci;

    ifmt_pkg::t_seg     cur;
    logic               end_seg;
    logic [3:0]         nxt;
    logic               has_next;
    logic [3:0]         pend_first;
    logic               last;
    logic               take;

    always_comb begin
        cur      = r_segs[r_si];
        end_seg  = (r_ci == cur.len - 3'd1);
        nxt      = r_si;
        has_next = 1'b0;
        for (int k = ifmt_pkg::NUM_LANES - 1; k >= 0; k--) begin
            if (4'(k) > r_si && r_segs[k].len != 3'd0) begin
                nxt      = 4'(k);
                has_next = 1'b1;
            end
        end
        pend_first = '0;
        for (int k = ifmt_pkg::NUM_LANES - 1; k >= 0; k--) begin
            if (r_pend[k].len != 3'd0) begin
                pend_first = 4'(k);
            end
        end
        last        = r_act && end_seg && !has_next;
        take        = r_pend_v && (!r_act || last);
        o_seg_ready = !r_pend_v || take;
    end

    always_comb begin
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_act    = r_act;
        n_segs   = r_segs;
        n_si     = r_si;
        n_ci     = r_ci;
        if (i_seg_valid && o_seg_ready) begin
            n_pend_v = 1'b1;
            n_pend   = i_segs;
        end else if (take) begin
            n_pend_v = 1'b0;
        end
        if (take) begin
            n_act  = 1'b1;
            n_segs = r_pend;
            n_si   = pend_first;
            n_ci   = '0;
        end else if (last) begin
            n_act = 1'b0;
        end else if (r_act) begin
            if (end_seg) begin
                n_si = nxt;
                n_ci = '0;
            end else begin
                n_ci = r_ci + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_act    <= 1'b0;
            r_si     <= '0;
            r_ci     <= '0;
        end else begin
            r_pend_v <= n_pend_v;
            r_act    <= n_act;
            r_si     <= n_si;
            r_ci     <= n_ci;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_segs <= n_segs;
    end

    assign o_strobe    = r_act;
    assign o_text_char = cur.chars[r_ci];
    assign o_last_char = last;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench of the IP address text formatter unit.
`default_nettype none
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 290;

    typedef struct packed {
        logic [ifmt_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_text_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [4:0]  i_addr_len = '0;
    logic [63:0] i_addr_high = '0;
    logic [63:0] i_addr_low = '0;
    wire logic   o_busy;
    wire logic   o_strobe;
    wire logic [6:0] o_text_char;
    wire logic   o_last_char;

    ip_address_text_formatter_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_addr_len  (i_addr_len),
        .i_addr_high (i_addr_high),
        .i_addr_low  (i_addr_low),
        .o_strobe    (o_strobe),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_text_item                  pending_chars[$];
    logic [ifmt_pkg::CHAR_W-1:0] text_buf[$];
    int                          mismatch_count = 0;
    int                          cycle_count = 0;
    t_text_item                  oldest_char;

    logic [4:0]  row_len[$];
    logic [63:0] row_high[$];
    logic [63:0] row_low[$];
    string       row_text[$];

    // ---------------------------------------------------------------- text predictor

    function automatic logic [7:0] addr_byte(input logic [63:0] hi, input logic [63:0] lo,
                                             input int idx);
        logic [63:0] w;
        w = (idx < 8) ? hi : lo;
        return w[63 - 8 * (idx % 8) -: 8];
    endfunction

    function automatic void put_hex(input logic [3:0] nib);
        if (nib < 4'd10) begin
            text_buf.push_back(ifmt_pkg::CH_ZERO + {3'b000, nib});
        end else begin
            text_buf.push_back(ifmt_pkg::CH_LOWA + {3'b000, nib} - 7'd10);
        end
    endfunction

    function automatic void put_dec(input int v);
        if (v >= 100) begin
            put_hex(4'(v / 100));
        end
        if (v >= 10) begin
            put_hex(4'((v / 10) % 10));
        end
        put_hex(4'(v % 10));
    endfunction

    function automatic void put_dotted(input logic [63:0] hi, input logic [63:0] lo,
                                       input int first);
        for (int k = 0; k < 4; k++) begin
            if (k > 0) begin
                text_buf.push_back(ifmt_pkg::CH_DOT);
            end
            put_dec(int'(addr_byte(hi, lo, first + k)));
        end
    endfunction

    function automatic void put_group(input logic [15:0] g);
        logic started;
        started = 1'b0;
        for (int sh = 12; sh >= 0; sh -= 4) begin
            if (g[sh +: 4] != 4'd0 || started || sh == 0) begin
                put_hex(g[sh +: 4]);
                started = 1'b1;
            end
        end
    endfunction

    function automatic void put_groups(input logic [63:0] hi, input logic [63:0] lo);
        logic [15:0] grp[8];
        int          i;
        int          j;
        int          run_start;
        int          run_len;
        for (int g = 0; g < 8; g++) begin
            grp[g] = {addr_byte(hi, lo, 2 * g), addr_byte(hi, lo, 2 * g + 1)};
        end
        // find the first longest run of zero groups
        run_start = 0;
        run_len = 0;
        i = 0;
        while (i < 8) begin
            j = i;
            while (j < 8 && grp[j] == 16'd0) begin
                j++;
            end
            if (j - i > run_len) begin
                run_start = i;
                run_len = j - i;
            end
            i = (j > i) ? j : i + 1;
        end
        if (run_len < 2) begin
            run_len = 0;
        end
        i = 0;
        while (i < 8) begin
            if (run_len != 0 && i == run_start) begin
                text_buf.push_back(ifmt_pkg::CH_COLON);
                text_buf.push_back(ifmt_pkg::CH_COLON);
                i += run_len;
                if (i >= 8) begin
                    break;
                end
            end else if (i > 0) begin
                text_buf.push_back(ifmt_pkg::CH_COLON);
            end
            put_group(grp[i]);
            i++;
        end
    endfunction

    // Move the built text into the expected queue, marking its final character.
    function automatic void queue_text();
        t_text_item e;
        for (int k = 0; k < text_buf.size(); k++) begin
            e.ch = text_buf[k];
            e.last = (k == text_buf.size() - 1);
            pending_chars.push_back(e);
        end
        text_buf.delete();
    endfunction

    function automatic void format_address(input logic [4:0] len, input logic [63:0] hi,
                                           input logic [63:0] lo);
        int          cnt;
        logic [7:0]  b;
        text_buf.delete();
        if (len == 5'd0) begin
            text_buf.push_back(ifmt_pkg::CH_LT);
            text_buf.push_back(ifmt_pkg::CH_N);
            text_buf.push_back(ifmt_pkg::CH_I);
            text_buf.push_back(ifmt_pkg::CH_L);
            text_buf.push_back(ifmt_pkg::CH_GT);
        end else if (len == 5'd4) begin
            put_dotted(hi, lo, 0);
        end else if (len == 5'd16) begin
            if (hi == 64'd0 && lo[63:32] == 32'h0000_ffff) begin
                put_dotted(hi, lo, 12);
            end else begin
                put_groups(hi, lo);
            end
        end else begin
            cnt = (len > 5'd16) ? 16 : int'(len);
            text_buf.push_back(ifmt_pkg::CH_QUEST);
            for (int k = 0; k < cnt; k++) begin
                b = addr_byte(hi, lo, k);
                put_hex(b[7:4]);
                put_hex(b[3:0]);
            end
        end
        queue_text();
    endfunction

    function automatic void expect_text(input string s);
        byte c;
        text_buf.delete();
        for (int k = 0; k < s.len(); k++) begin
            c = s[k];
            text_buf.push_back(c[6:0]);
        end
        queue_text();
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    task automatic send_addr(input logic [4:0] len, input logic [63:0] hi,
                             input logic [63:0] lo);
        @(negedge i_clk);
        i_addr_len <= len;
        i_addr_high <= hi;
        i_addr_low <= lo;
        i_start <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_busy);
    endtask

    task automatic hold_off(input int n);
        @(negedge i_clk);
        i_start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic add_row(input logic [4:0] len, input logic [63:0] hi, input logic [63:0] lo,
                           input string text);
        row_len.push_back(len);
        row_high.push_back(hi);
        row_low.push_back(lo);
        row_text.push_back(text);
    endtask

    // Bias toward zero groups and short groups so runs and leading zeros show up.
    function automatic logic [15:0] random_group();
        logic [15:0] g;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: g = 16'd0;
            4:          g = 16'hffff;
            default: begin
                g = 16'($urandom);
                g = g >> (4 * $urandom_range(0, 3));
            end
        endcase
        return g;
    endfunction

    function automatic logic [7:0] random_octet();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(0, 9));
            1:       return 8'($urandom_range(10, 99));
            default: return 8'($urandom_range(100, 255));
        endcase
    endfunction

    // ---------------------------------------------------------------- result checking

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected char: actual %h last %b", o_text_char, o_last_char);
                end
            end else begin
                oldest_char = pending_chars.pop_front();
                if (oldest_char.ch !== o_text_char || oldest_char.last !== o_last_char) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("char mismatch: expected %h last %b, actual %h last %b",
                                 oldest_char.ch, oldest_char.last, o_text_char, o_last_char);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        logic [4:0]  len;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] grp[8];
        int          kind;

        add_row(5'd0, 64'h0123_4567_89ab_cdef, 64'hffff_0000_ffff_0000, "<nil>");
        add_row(5'd4, 64'd0, 64'd0, "0.0.0.0");
        add_row(5'd4, 64'hffff_ffff_1234_5678, 64'h5a5a_5a5a_5a5a_5a5a, "255.255.255.255");
        add_row(5'd4, 64'hc0a8_0101_0000_0000, 64'd0, "192.168.1.1");
        add_row(5'd16, 64'd0, 64'd0, "::");
        add_row(5'd16, '1, '1, "ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff");
        add_row(5'd16, 64'd0, 64'h0000_ffff_0a00_0001, "10.0.0.1");
        add_row(5'd16, 64'd0, 64'h0100_ffff_0a00_0001, "");
        add_row(5'd16, 64'd0, 64'h0000_fffe_0a00_0001, "");
        add_row(5'd16, 64'd0, 64'd1, "::1");
        add_row(5'd16, 64'h0001_0000_0000_0000, 64'd0, "1::");
        // a lone zero group stays a plain zero
        add_row(5'd16, 64'h0001_0000_0001_0001, 64'h0001_0001_0001_0001, "1:0:1:1:1:1:1:1");
        // equal runs: the first one is compressed
        add_row(5'd16, 64'h0001_0000_0000_0001, 64'h0000_0000_0001_0001, "1::1:0:0:1:1");
        add_row(5'd16, 64'h0001_0000_0000_0001, 64'h0000_0000_0000_0001, "");
        add_row(5'd16, 64'd0, 64'h0005_0000_0000_0000, "");
        add_row(5'd16, 64'h0abc_00de_000f_1000, 64'h0100_0010_0001_f00d, "");
        add_row(5'd16, 64'd0, 64'hffff_ffff_0000_0000, "");
        add_row(5'd1, 64'hff00_0000_0000_0000, 64'd0, "?ff");
        add_row(5'd3, 64'h0a1b_2c3d_4e5f_6071, 64'hffff_ffff_ffff_ffff, "");
        add_row(5'd5, 64'h0102_0304_05ff_eedd, 64'd0, "");
        add_row(5'd15, 64'hfedc_ba98_7654_3210, 64'h0123_4567_89ab_cdef, "");
        add_row(5'd17, 64'h8040_2010_0804_0201, 64'h7fbf_dfef_f7fb_fdfe, "");
        add_row(5'd31, '1, '1, {"?", "ffffffffffffffff", "ffffffffffffffff"});

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < row_len.size(); r++) begin
            if ($urandom_range(0, 99) < 15) begin
                hold_off($urandom_range(1, 6));
            end
            send_addr(row_len[r], row_high[r], row_low[r]);
            if (row_text[r].len() == 0) begin
                format_address(row_len[r], row_high[r], row_low[r]);
            end else begin
                expect_text(row_text[r]);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind = $urandom_range(0, 19);
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
            if (kind <= 9) begin
                len = 5'd16;
                for (int g = 0; g < 8; g++) begin
                    grp[g] = random_group();
                end
                hi = {grp[0], grp[1], grp[2], grp[3]};
                lo = {grp[4], grp[5], grp[6], grp[7]};
            end else if (kind <= 11) begin
                len = 5'd16;
                hi = 64'd0;
                lo[63:32] = 32'h0000_ffff;
                // spoil the mapped prefix now and then
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 1) == 0) begin
                        hi[$urandom_range(0, 63)] = 1'b1;
                    end else begin
                        lo[$urandom_range(32, 63)] ^= 1'b1;
                    end
                end
            end else if (kind <= 14) begin
                len = 5'd4;
                hi[63:32] = {random_octet(), random_octet(), random_octet(), random_octet()};
            end else if (kind == 15) begin
                len = 5'd0;
            end else begin
                do begin
                    len = 5'($urandom_range(1, 31));
                end while (len == 5'd4 || len == 5'd16);
            end
            // keep a long stretch free of gaps
            if ((n < 120 || n >= 200) && $urandom_range(0, 99) < 15) begin
                hold_off($urandom_range(1, 6));
            end
            send_addr(len, hi, lo);
            format_address(len, hi, lo);
        end

        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/ifmt_pkg.sv
design/ifmt_scan.sv
design/ifmt_lane.sv
design/ifmt_emit.sv
design/ip_address_text_formatter_unit.sv
sim/testbench.sv
